// ----- hw/rtl/fed_pkg.sv -----
package fed_pkg;

	// Depth of the echo memory in samples; a power of two.
	localparam int unsigned DEPTH = 65536;
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned LEN_W = PTR_W + 1;

	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned DELAY_W = 17;
	localparam int unsigned FB_W = 15;
	localparam int unsigned WET_W = 16;
	localparam int unsigned SAT_IN_W = 20;

	localparam int unsigned PADDR_W = 4;
	localparam int unsigned PDATA_W = 32;

	localparam int unsigned OUTQ_AW = 2;
	localparam int unsigned OUTQ_DEPTH = 2 ** OUTQ_AW;
	localparam int unsigned OUTQ_CW = OUTQ_AW + 1;

	localparam logic [DELAY_W-1:0] DELAY_RESET = 17'd13230;
	localparam logic [FB_W-1:0] FEEDBACK_RESET = 15'd16384;
	localparam logic [WET_W-1:0] WET_RESET = 16'd9830;
	localparam logic [WET_W-1:0] Q15_ONE = 16'h8000;

	typedef enum logic [1:0] {
		REG_DELAY = 2'd0,
		REG_FEEDBACK = 2'd1,
		REG_WET = 2'd2
	} reg_idx_t;

	// Effective configuration seen by the datapath.
	typedef struct packed {
		logic [LEN_W-1:0] eff_len;
		logic [FB_W-1:0] fb_gain;
		logic [WET_W-1:0] wet;
		logic [WET_W-1:0] dry;
		logic restart;
		logic [PTR_W-1:0] restart_wr;
	} cfg_t;

	typedef struct packed {
		logic clearing;
		logic busy;
	} core_sts_t;

	function automatic logic [LEN_W-1:0] clamp_len(input logic [DELAY_W-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		if (w < 32'd2) begin
			w = 32'd2;
		end else if (w > 32'(DEPTH)) begin
			w = 32'(DEPTH);
		end
		return LEN_W'(w);
	endfunction

	function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
			input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] n;
		n = {1'b0, p} + LEN_W'(1);
		return (n >= len) ? '0 : n[PTR_W-1:0];
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SAT_IN_W-1:0] v);
		if (v > 20'sd32767) begin
			return 16'sh7fff;
		end else if (v < -20'sd32768) begin
			return 16'sh8000;
		end
		return v[SAMPLE_W-1:0];
	endfunction

	localparam logic [PTR_W-1:0] WR_RESET = PTR_W'(clamp_len(DELAY_RESET) - LEN_W'(1));

endpackage

// ----- hw/rtl/feedback_echo_delay_top.sv -----
// Feedback echo on a circular delay memory of 65536 signed Q1.15 samples. Each input item
// gives one output item: the tap at the read pointer, scaled by the feedback gain, is added
// to the input, saturated and written behind the read pointer, and the output mixes the
// next tap with the input by the wet weight. The block takes no new item while the second
// read of the last one is pending, as each item needs two reads of the memory's single
// read port; the result passes stages s1 to s4 and waits in a four-deep output queue,
// so a stalled output side holds back the input only once that queue is committed.
// After reset the memory is swept to zero, one word a cycle, and no item is taken until
// the sweep is done; configuration writes are taken during that time. Writing the delay
// length restarts both pointers and keeps the memory contents. Registers sit at byte
// addresses 0 (delay length), 4 (feedback gain) and 8 (wet mix).
module feedback_echo_delay_top import fed_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	output logic sample_ready,
	input logic signed [SAMPLE_W-1:0] sample_in,
	output logic result_valid,
	input logic result_ready,
	output logic signed [SAMPLE_W-1:0] sample_out,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [PADDR_W-1:0] paddr,
	input logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic pready
);

	cfg_t cfg;
	core_sts_t sts;
	logic in_acc;
	logic out_acc;
	logic push;
	logic signed [SAMPLE_W-1:0] push_data;
	// Items taken whose result has not yet left; bounded by the output queue depth.
	logic [OUTQ_CW-1:0] inflight_q;

	assign pready = 1'b1;

	fed_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.cfg(cfg)
	);

	// An item is taken when the memory is not being swept, the read port is free and a
	// queue slot is reserved for its result.
	assign sample_ready = !sts.clearing && !sts.busy
		&& (inflight_q != OUTQ_CW'(OUTQ_DEPTH));
	assign in_acc = sample_valid & sample_ready;
	assign out_acc = result_valid & result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			unique case ({in_acc, out_acc})
				2'b10: inflight_q <= inflight_q + OUTQ_CW'(1);
				2'b01: inflight_q <= inflight_q - OUTQ_CW'(1);
				default: ;
			endcase
		end
	end

	fed_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.acc(in_acc),
		.sample_in(sample_in),
		.cfg(cfg),
		.sts(sts),
		.push(push),
		.push_data(push_data)
	);

	fed_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.pop(out_acc),
		.valid(result_valid),
		.data(sample_out)
	);

	// The reservation count never exceeds the queue depth.
	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= OUTQ_CW'(OUTQ_DEPTH))
		else $error("in-flight count above output queue depth");

	// A waiting result always belongs to an item that was counted in.
	a_result_counted: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (inflight_q != '0))
		else $error("result shown with no item in flight");

	// Two items are never taken in adjacent cycles: the second read owns the port.
	a_item_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_acc)
		else $error("items taken in adjacent cycles");

	// No item is taken while the memory sweep is running.
	a_no_item_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		sts.clearing |-> !in_acc)
		else $error("item taken during memory sweep");

endmodule

// ----- hw/rtl/fed_ram.sv -----
module fed_ram #(
	parameter int unsigned ADDR_W = 16,
	parameter int unsigned DATA_W = 16
) (
	input logic clk,
	input logic we,
	input logic [ADDR_W-1:0] waddr,
	input logic [DATA_W-1:0] wdata,
	input logic re,
	input logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read returns the old word when the same entry is written in that cycle.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/fed_regs.sv -----
module fed_regs import fed_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [PADDR_W-1:0] paddr,
	input logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output cfg_t cfg
);

	logic [DELAY_W-1:0] delay_len_q;
	logic [FB_W-1:0] fb_gain_q;
	logic [WET_W-1:0] wet_mix_q;
	logic wr_en;
	reg_idx_t idx;

	assign wr_en = psel & penable & pwrite;
	assign idx = reg_idx_t'(paddr[PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_len_q <= DELAY_RESET;
			fb_gain_q <= FEEDBACK_RESET;
			wet_mix_q <= WET_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_DELAY: delay_len_q <= pwdata[DELAY_W-1:0];
				REG_FEEDBACK: fb_gain_q <= pwdata[FB_W-1:0];
				REG_WET: wet_mix_q <= pwdata[WET_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_DELAY: prdata = PDATA_W'(delay_len_q);
			REG_FEEDBACK: prdata = PDATA_W'(fb_gain_q);
			REG_WET: prdata = PDATA_W'(wet_mix_q);
			default: prdata = '0;
		endcase
	end

	always_comb begin
		cfg.eff_len = clamp_len(delay_len_q);
		cfg.fb_gain = fb_gain_q;
		cfg.wet = (wet_mix_q > Q15_ONE) ? Q15_ONE : wet_mix_q;
		cfg.dry = Q15_ONE - cfg.wet;
		cfg.restart = wr_en && (idx == REG_DELAY);
		cfg.restart_wr = PTR_W'(clamp_len(pwdata[DELAY_W-1:0]) - LEN_W'(1));
	end

endmodule

// ----- hw/rtl/fed_core.sv -----
module fed_core import fed_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic acc,
	input logic signed [SAMPLE_W-1:0] sample_in,
	input cfg_t cfg,
	output core_sts_t sts,
	output logic push,
	output logic signed [SAMPLE_W-1:0] push_data
);

	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic clr_q;
	logic [PTR_W-1:0] clr_addr_q;

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic valid_s4;
	logic signed [SAMPLE_W-1:0] x_s1;
	logic signed [SAMPLE_W-1:0] x_s2;
	logic signed [SAMPLE_W-1:0] x_s3;
	logic signed [31:0] prod_fb_s2;
	logic [PTR_W-1:0] rd2_s2;
	logic signed [SAMPLE_W-1:0] tap2_s3;
	logic signed [32:0] wet_p_s4;
	logic signed [32:0] dry_p_s4;

	logic re;
	logic we;
	logic [PTR_W-1:0] waddr;
	logic [SAMPLE_W-1:0] wdata;
	logic [SAMPLE_W-1:0] ram_rdata;
	logic byp_q;
	logic [SAMPLE_W-1:0] byp_data_q;
	logic signed [SAMPLE_W-1:0] rdat;

	logic signed [32:0] fb_t;
	logic signed [SAT_IN_W-1:0] fb_sum;
	logic signed [SAMPLE_W-1:0] store;
	logic signed [33:0] mix_sum;
	logic signed [34:0] mix_t;

	// First read at acceptance, second read in the following cycle, both at the read pointer.
	assign re = acc | valid_s1;
	assign we = clr_q | valid_s2;
	assign waddr = clr_q ? clr_addr_q : wr_ptr_q;
	assign wdata = clr_q ? '0 : store;

	fed_ram #(
		.ADDR_W(PTR_W),
		.DATA_W(SAMPLE_W)
	) u_ram (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.re(re),
		.raddr(rd_ptr_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (re) begin
			byp_q <= we && (waddr == rd_ptr_q);
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			byp_data_q <= wdata;
		end
	end

	assign rdat = byp_q ? $signed(byp_data_q) : $signed(ram_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= WR_RESET;
			clr_q <= 1'b1;
			clr_addr_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= acc;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + PTR_W'(1);
				if (clr_addr_q == '1) begin
					clr_q <= 1'b0;
				end
			end
			if (cfg.restart) begin
				rd_ptr_q <= '0;
				wr_ptr_q <= cfg.restart_wr;
			end else begin
				if (acc) begin
					rd_ptr_q <= advance(rd_ptr_q, cfg.eff_len);
				end
				if (valid_s2) begin
					wr_ptr_q <= advance(wr_ptr_q, cfg.eff_len);
				end
			end
		end
	end

	// Feedback: round the tap product and add the input, saturated.
	always_comb begin
		fb_t = 33'(prod_fb_s2) + 33'sd16384;
		fb_sum = SAT_IN_W'($signed(fb_t[32:15])) + SAT_IN_W'(x_s2);
		store = sat16(fb_sum);
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			prod_fb_s2 <= rdat * $signed({1'b0, cfg.fb_gain});
			x_s2 <= x_s1;
			rd2_s2 <= rd_ptr_q;
		end
		if (acc) begin
			x_s1 <= sample_in;
		end
		if (valid_s2) begin
			// At a length of two the second tap is the word written now.
			tap2_s3 <= (rd2_s2 == wr_ptr_q) ? store : rdat;
			x_s3 <= x_s2;
		end
		if (valid_s3) begin
			wet_p_s4 <= tap2_s3 * $signed({1'b0, cfg.wet});
			dry_p_s4 <= x_s3 * $signed({1'b0, cfg.dry});
		end
	end

	always_comb begin
		mix_sum = 34'(wet_p_s4) + 34'(dry_p_s4);
		mix_t = 35'(mix_sum) + 35'sd16384;
		push_data = sat16($signed(mix_t[34:15]));
	end

	assign push = valid_s4;
	assign sts.clearing = clr_q;
	assign sts.busy = valid_s1;

endmodule

// ----- hw/rtl/fed_outq.sv -----
module fed_outq import fed_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic signed [SAMPLE_W-1:0] push_data,
	input logic pop,
	output logic valid,
	output logic signed [SAMPLE_W-1:0] data
);

	logic signed [SAMPLE_W-1:0] entry_q [OUTQ_DEPTH];
	logic [OUTQ_AW-1:0] wp_q;
	logic [OUTQ_AW-1:0] rp_q;
	logic [OUTQ_CW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + OUTQ_AW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + OUTQ_AW'(1);
			end
			unique case ({push, pop})
				2'b10: cnt_q <= cnt_q + OUTQ_CW'(1);
				2'b01: cnt_q <= cnt_q - OUTQ_CW'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wp_q] <= push_data;
		end
	end

	assign valid = (cnt_q != '0);
	assign data = entry_q[rp_q];

endmodule

// ----- sim/tb_feedback_echo_delay_top.sv -----
// Self-checking testbench for the feedback echo block.
//
// Items are queued by the main initial block and handed to the block by a clocked driver,
// which also runs the predictor at the moment an item is accepted. The predictor keeps its
// own echo memory, pointers and register copies, and pushes the expected mixed sample onto
// a queue. A clocked monitor pops that queue for every result the block hands back and
// compares the sample field. Registers are only written when nothing is in flight.
module tb_feedback_echo_delay_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fed_pkg::*;

	// Index of a register slot that is decoded by nobody; writes to it must be ignored.
	localparam int unsigned REG_UNUSED = 3;
	localparam longint UNITY = 32768;
	// Cycles allowed after the last result before the block counts as quiet.
	localparam int unsigned SETTLE_CYCLES = 20;
	// Length of the long output stall used to back the block up.
	localparam int unsigned HOLD_CYCLES = 400;
	// Timeout for the whole run, clearing sweep included, even with the heaviest
	// idling.
	localparam int unsigned RUN_LIMIT = 1000000;
	localparam int unsigned RANDOM_PHASES = 8;
	localparam int unsigned PHASE_ITEMS = 110;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_ready;
	logic signed [SAMPLE_W-1:0] sample_in = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	feedback_echo_delay_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample_in(sample_in),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.sample_out(sample_out),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	// Predictor state: a private copy of the echo memory, the two pointers and the registers.
	logic signed [SAMPLE_W-1:0] echo_mem [DEPTH];
	int unsigned rd_ptr;
	int unsigned wr_ptr;
	int unsigned eff_len;
	logic [DELAY_W-1:0] delay_reg;
	logic [FB_W-1:0] fb_reg;
	logic [WET_W-1:0] wet_reg;

	// Items waiting to be offered, and mixed samples the block still owes us.
	logic signed [SAMPLE_W-1:0] sample_pending [$];
	logic signed [SAMPLE_W-1:0] mix_due [$];

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int err_count = 0;
	int n_taken = 0;
	int n_checked = 0;
	int n_settings = 0;
	int hold_trigger = 0;
	int hold_seen = 0;
	int unsigned hold_left = 0;
	int unsigned cycle_count = 0;

	// Saturate a wide value to the signed 16-bit range.
	function automatic logic signed [SAMPLE_W-1:0] clip16(input longint v);
		if (v > 32767) begin
			return 16'sh7fff;
		end else if (v < -32768) begin
			return 16'sh8000;
		end
		return v[SAMPLE_W-1:0];
	endfunction

	// Drop the 15 fraction bits, rounding to nearest with ties going up.
	function automatic longint q15_round(input longint v);
		return (v + 64'sd16384) >>> 15;
	endfunction

	function automatic int unsigned step_ptr(input int unsigned p);
		return (p + 1 >= eff_len) ? 0 : p + 1;
	endfunction

	// The delay register takes effect clamped to 2..DEPTH and always restarts the pointers,
	// with the write pointer one behind the read pointer around the loop.
	function automatic void restart_ptrs();
		if (delay_reg < 2) begin
			eff_len = 2;
		end else if (delay_reg > DEPTH) begin
			eff_len = DEPTH;
		end else begin
			eff_len = 32'(delay_reg);
		end
		rd_ptr = 0;
		wr_ptr = eff_len - 1;
	endfunction

	// Add one item to the tail of the pending list.
	function automatic void queue_item(input logic signed [SAMPLE_W-1:0] s);
		sample_pending = {sample_pending, s};
	endfunction

	// One step of the echo: feed the scaled tap back into the memory, move both pointers,
	// then blend the word now under the read pointer with the dry input.
	function automatic logic signed [SAMPLE_W-1:0] echo_predict(
			input logic signed [SAMPLE_W-1:0] x);
		longint xs;
		longint tap;
		longint fb;
		longint wet;
		longint acc;
		xs = longint'(x);
		tap = longint'(echo_mem[rd_ptr]);
		fb = q15_round(tap * longint'(fb_reg));
		echo_mem[wr_ptr] = clip16(xs + fb);
		rd_ptr = step_ptr(rd_ptr);
		wr_ptr = step_ptr(wr_ptr);
		// A wet weight above unity saturates at fully wet with no dry part.
		wet = (longint'(wet_reg) > UNITY) ? UNITY : longint'(wet_reg);
		acc = longint'(echo_mem[rd_ptr]) * wet + xs * (UNITY - wet);
		return clip16(q15_round(acc));
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			default: return SAMPLE_W'($urandom());
		endcase
	endfunction

	// APB write: setup cycle, then access cycle. pready is always high, so the register
	// takes the value at the edge that ends the access cycle, and the predictor follows.
	task automatic reg_write(input int unsigned idx, input logic [PDATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(idx * 4);
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_DELAY: begin
				delay_reg = data[DELAY_W-1:0];
				restart_ptrs();
			end
			REG_FEEDBACK: fb_reg = data[FB_W-1:0];
			REG_WET: wet_reg = data[WET_W-1:0];
			default: ;
		endcase
		n_settings++;
	endtask

	// Wait until every queued item has been taken and every result has come back, then let
	// the clock run on for the settle time so that a stray extra result would still be seen.
	task automatic drain();
		while (sample_pending.size() != 0 || mix_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Input driver. The predictor runs here, at the edge that accepts the item, so the
	// expected sample is queued before the block can possibly answer it.
	always @(posedge clk) begin
		logic taken;
		logic signed [SAMPLE_W-1:0] y;
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else begin
			taken = sample_valid && sample_ready;
			if (taken) begin
				y = echo_predict(sample_in);
				mix_due = {mix_due, y};
				void'(sample_pending.pop_front());
				n_taken++;
			end
			// An item on offer stays put, payload and all, until it is accepted.
			if (sample_valid && !taken) begin
			end else if (sample_pending.size() != 0 &&
					$urandom_range(0, 99) >= tx_idle_pct) begin
				sample_valid <= 1'b1;
				sample_in <= sample_pending[0];
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	// Long output stall, counted down in its own process. The main block asks for one by
	// bumping hold_trigger.
	always @(posedge clk) begin
		if (hold_trigger != hold_seen) begin
			hold_seen <= hold_trigger;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Result monitor: every accepted result is checked against the oldest expected sample.
	always @(posedge clk) begin
		logic signed [SAMPLE_W-1:0] want;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (mix_due.size() == 0) begin
					$display("%0t: unexpected result, expected none, got %0d", $time,
						sample_out);
					err_count++;
				end else begin
					want = mix_due.pop_front();
					n_checked++;
					if (sample_out !== want) begin
						$display("%0t: sample_out mismatch, expected %0d, got %0d", $time,
							want, sample_out);
						err_count++;
					end
				end
			end
		end
		result_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= rx_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("tb_feedback_echo_delay_top NOT OK");
			$finish;
		end
	end

	initial begin
		logic [PDATA_W-1:0] data;
		int unsigned first;
		int unsigned idx;
		logic [DELAY_W-1:0] dlen;

		// The memory comes out of reset all zero and the registers at their reset values.
		foreach (echo_mem[i]) begin
			echo_mem[i] = '0;
		end
		delay_reg = DELAY_RESET;
		fb_reg = FEEDBACK_RESET;
		wet_reg = WET_RESET;
		restart_ptrs();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// The block sweeps its memory after reset; register writes are taken meanwhile.
		// A write to the undecoded slot must change nothing.
		reg_write(REG_UNUSED, 32'hffff_ffff);

		// A few items at the reset settings, reading from the freshly cleared memory.
		queue_item(16'sh8000);
		queue_item(16'sh7fff);
		queue_item(16'sh0000);
		drain();

		// Shortest loop: the word just written is read straight back. Full feedback and a
		// fully wet mix drive the stored sum into saturation both ways.
		reg_write(REG_DELAY, 32'd2);
		reg_write(REG_FEEDBACK, 32'd32767);
		reg_write(REG_WET, 32'd32768);
		repeat (3) queue_item(16'sh7fff);
		repeat (3) queue_item(16'sh8000);
		drain();

		// Delay lengths below two act as two. Wet above unity acts as fully wet, wet zero
		// gives the dry input alone. Upper data bits beyond the register width are dropped.
		reg_write(REG_DELAY, 32'd0);
		reg_write(REG_FEEDBACK, 32'd0);
		reg_write(REG_WET, 32'h0000_ffff);
		queue_item(16'sh0001);
		queue_item(16'shffff);
		queue_item(16'sh7fff);
		drain();
		reg_write(REG_DELAY, 32'hfffe_0001);
		reg_write(REG_WET, 32'hffff_0000);
		queue_item(16'sh8000);
		queue_item(16'sh5555);
		queue_item(16'shaaaa);
		drain();

		// Delay lengths above the memory depth act as the full depth.
		reg_write(REG_DELAY, 32'h0001_ffff);
		reg_write(REG_FEEDBACK, 32'h0000_7fff);
		reg_write(REG_WET, 32'd16384);
		queue_item(16'sh7fff);
		queue_item(16'sh8000);
		queue_item(16'sh1234);
		drain();
		reg_write(REG_DELAY, DEPTH);
		queue_item(16'sh7fff);
		queue_item(16'sh8000);
		queue_item(16'shedcb);
		drain();

		// Random phases. Each picks new settings, mostly short delays so that the echo
		// comes round many times, and one of four idling patterns.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			first = $urandom_range(0, 2);
			for (int k = 0; k < 3; k++) begin
				idx = (first + k) % 3;
				data = $urandom();
				case (idx)
					REG_DELAY: begin
						case ($urandom_range(0, 9))
							7: dlen = DELAY_W'($urandom_range(0, 1));
							8: dlen = DELAY_W'($urandom_range(41, 1000));
							9: dlen = DELAY_W'($urandom());
							default: dlen = DELAY_W'($urandom_range(2, 40));
						endcase
						data[DELAY_W-1:0] = dlen;
						// Sometimes leave the delay alone so the pointers run on from the
						// previous phase.
						if (ph == 0 || $urandom_range(0, 3) != 0) begin
							reg_write(REG_DELAY, data);
						end
					end
					REG_FEEDBACK: begin
						case ($urandom_range(0, 3))
							0: data[FB_W-1:0] = '0;
							1: data[FB_W-1:0] = '1;
							default: ;
						endcase
						reg_write(REG_FEEDBACK, data);
					end
					default: begin
						case ($urandom_range(0, 3))
							0: data[WET_W-1:0] = '0;
							1: data[WET_W-1:0] = Q15_ONE;
							2: data[WET_W-1:0] = WET_W'($urandom_range(32769, 65535));
							default: data[WET_W-1:0] = WET_W'($urandom_range(0, 32768));
						endcase
						reg_write(REG_WET, data);
					end
				endcase
			end
			if ($urandom_range(0, 3) == 0) begin
				reg_write(REG_UNUSED, $urandom());
			end

			case (ph % 4)
				0: begin
					tx_idle_pct = 0;
					rx_stall_pct = 0;
				end
				1: begin
					tx_idle_pct = 85;
					rx_stall_pct = 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_stall_pct = 85;
				end
				default: begin
					tx_idle_pct = 18;
					rx_stall_pct = 18;
				end
			endcase

			// In the first phase the output side holds off for a long stretch while the
			// sender keeps offering, so the output queue fills and the input backs up.
			if (ph == 0) begin
				@(posedge clk);
				hold_trigger <= hold_trigger + 1;
			end

			// Mostly random samples, with the odd burst of one repeated value to push the
			// feedback path into saturation.
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 15) == 0) begin
					data[SAMPLE_W-1:0] = rand_sample();
					for (int b = 0; b < 8 && n < PHASE_ITEMS; b++) begin
						queue_item(data[SAMPLE_W-1:0]);
						n++;
					end
				end else begin
					queue_item(rand_sample());
				end
			end
			drain();
			tx_idle_pct = 0;
			rx_stall_pct = 0;
		end

		$display("Run covered %0d items and %0d checked results over %0d register writes,",
			n_taken, n_checked, n_settings);
		$display("with short, clamped and full-depth delays, four idling patterns and a long stall.");
		if (err_count == 0 && mix_due.size() == 0) begin
			$display("tb_feedback_echo_delay_top OK");
		end else begin
			$display("tb_feedback_echo_delay_top NOT OK");
		end
		$finish;
	end

endmodule
